[rtl/core/acsp_pkg.sv]
package acsp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned PAL_W    = 4;
    localparam int unsigned PARAM_W  = 16;
    localparam int unsigned WIN_W    = 9;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'd1;

    localparam logic [WIN_W-1:0] WIDTH_RESET  = 9'd32;
    localparam logic [WIN_W-1:0] HEIGHT_RESET = 9'd24;

    localparam logic [BYTE_W-1:0] CH_BRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_DOWN    = 8'h42;
    localparam logic [BYTE_W-1:0] CH_RIGHT   = 8'h43;
    localparam logic [BYTE_W-1:0] CH_LEFT    = 8'h44;
    localparam logic [BYTE_W-1:0] CH_POS_H   = 8'h48;
    localparam logic [BYTE_W-1:0] CH_POS_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CH_CLR_SCR = 8'h4A;
    localparam logic [BYTE_W-1:0] CH_CLR_LN  = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_SAVE    = 8'h73;
    localparam logic [BYTE_W-1:0] CH_RESTORE = 8'h75;
    localparam logic [BYTE_W-1:0] CH_SET     = 8'h68;
    localparam logic [BYTE_W-1:0] CH_RESET   = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_SGR     = 8'h6D;

    localparam logic [PAL_W-1:0] PAL_DEFAULT = 4'd15;

    typedef enum logic [1:0] {
        CLEAR_NONE   = 2'd0,
        CLEAR_SCREEN = 2'd1,
        CLEAR_LINE   = 2'd2
    } clear_kind_t;

    typedef enum logic [1:0] {
        SGR_NORMAL      = 2'd0,
        SGR_TRUECOLOR   = 2'd1,
        SGR_WAIT_INDEX  = 2'd2,
        SGR_INDEX_TAKEN = 2'd3
    } sgr_mode_t;

endpackage

[rtl/core/acsp_if.sv]
interface acsp_seq_if;
    logic       valid;
    logic       ready;
    logic [7:0] seq_byte;
    logic       start_req;
    logic [7:0] cursor_col_in;
    logic [7:0] cursor_row_in;
    logic [3:0] palette_in;

    modport source (output valid, seq_byte, start_req, cursor_col_in, cursor_row_in,
                    palette_in, input ready);
    modport sink (input valid, seq_byte, start_req, cursor_col_in, cursor_row_in,
                  palette_in, output ready);
endinterface

interface acsp_res_if;
    logic       valid;
    logic       ready;
    logic       done_res;
    logic [7:0] consumed;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic [3:0] palette;
    logic [1:0] clear_kind;
    logic [7:0] clear_arg;

    modport source (output valid, done_res, consumed, cursor_col, cursor_row, palette,
                    clear_kind, clear_arg, input ready);
    modport sink (input valid, done_res, consumed, cursor_col, cursor_row, palette,
                  clear_kind, clear_arg, output ready);
endinterface

[rtl/core/ansi_csi_sequence_parser.sv]
// an accepted item passes through the input register, then its result shows from the result register
// throughput: one item per cycle while results drain; parse state updates as an item enters the result register
// the result register frees the input side, so a new item is taken while a result waits
// reset: parse state cleared, saved cursor 0, previous byte the bracket,
// window 32 columns by 24 rows, both registers empty
module ansi_csi_sequence_parser
    import acsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_data,
    acsp_seq_if.sink             seq_ch,
    acsp_res_if.source           res_ch
);

    logic [WIN_W-1:0] width_reg;
    logic [WIN_W-1:0] height_reg;

    logic               s1_valid_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic               s1_start_reg;
    logic [POS_W-1:0]   s1_col_reg;
    logic [POS_W-1:0]   s1_row_reg;
    logic [PAL_W-1:0]   s1_pal_reg;

    logic               out_valid_reg;
    logic               out_done_reg;
    logic [7:0]         out_cnt_reg;
    logic [POS_W-1:0]   out_col_reg;
    logic [POS_W-1:0]   out_row_reg;
    logic [PAL_W-1:0]   out_pal_reg;
    clear_kind_t        out_ck_reg;
    logic [BYTE_W-1:0]  out_ca_reg;

    logic [POS_W-1:0]   saved_col_reg, saved_col_next;
    logic [POS_W-1:0]   saved_row_reg, saved_row_next;
    logic [7:0]         count_reg, count_next;
    logic [PARAM_W-1:0] accum_reg, accum_next;
    logic               has_reg, has_next;
    logic [PARAM_W-1:0] first_reg, first_next;
    logic               first_v_reg, first_v_next;
    logic [PARAM_W-1:0] second_reg, second_next;
    logic               second_v_reg, second_v_next;
    logic [2:0]         idx_reg, idx_next;
    logic [PAL_W-1:0]   color_reg, color_next;
    logic               color_v_reg, color_v_next;
    logic               bright_reg, bright_next;
    sgr_mode_t          mode_reg, mode_next;
    logic [BYTE_W-1:0]  prev_reg, prev_next;

    logic               advance;
    logic               out_free;

    logic [7:0]         c_count;
    logic [PARAM_W-1:0] c_accum;
    logic               c_has;
    logic [PARAM_W-1:0] c_first;
    logic               c_first_v;
    logic [PARAM_W-1:0] c_second;
    logic               c_second_v;
    logic [2:0]         c_idx;
    logic [PAL_W-1:0]   c_color;
    logic               c_color_v;
    logic               c_bright;
    sgr_mode_t          c_mode;
    logic [BYTE_W-1:0]  c_prev;

    logic [PARAM_W-1:0] f_first;
    logic               f_first_v;
    logic [PARAM_W-1:0] f_second;
    logic               f_second_v;
    logic [2:0]         f_idx;
    logic [PAL_W-1:0]   f_color;
    logic               f_color_v;
    logic               f_bright;
    sgr_mode_t          f_mode;

    logic               is_digit;
    logic               is_final;
    logic               first_byte;
    logic [19:0]        acc_wide;
    logic [PARAM_W-1:0] amt;
    logic [POS_W-1:0]   lim_h;
    logic [POS_W-1:0]   lim_w;
    logic [PARAM_W:0]   sum_row;
    logic [PARAM_W:0]   sum_col;
    logic [PAL_W-1:0]   sgr_c;

    logic               r_done;
    logic [7:0]         r_cnt;
    logic [POS_W-1:0]   r_col;
    logic [POS_W-1:0]   r_row;
    logic [PAL_W-1:0]   r_pal;
    clear_kind_t        r_ck;
    logic [BYTE_W-1:0]  r_ca;

    assign out_free     = !out_valid_reg || res_ch.ready;
    assign advance      = s1_valid_reg && out_free;
    assign seq_ch.ready = !s1_valid_reg || out_free;

    assign res_ch.valid      = out_valid_reg;
    assign res_ch.done_res   = out_done_reg;
    assign res_ch.consumed   = out_cnt_reg;
    assign res_ch.cursor_col = out_col_reg;
    assign res_ch.cursor_row = out_row_reg;
    assign res_ch.palette    = out_pal_reg;
    assign res_ch.clear_kind = out_ck_reg;
    assign res_ch.clear_arg  = out_ca_reg;

    // parse state as seen by this item, after an optional restart
    always_comb
    begin
        c_count    = s1_start_reg ? 8'd0 : count_reg;
        c_accum    = s1_start_reg ? '0 : accum_reg;
        c_has      = s1_start_reg ? 1'b0 : has_reg;
        c_first    = s1_start_reg ? '0 : first_reg;
        c_first_v  = s1_start_reg ? 1'b0 : first_v_reg;
        c_second   = s1_start_reg ? '0 : second_reg;
        c_second_v = s1_start_reg ? 1'b0 : second_v_reg;
        c_idx      = s1_start_reg ? 3'd0 : idx_reg;
        c_color    = s1_start_reg ? '0 : color_reg;
        c_color_v  = s1_start_reg ? 1'b0 : color_v_reg;
        c_bright   = s1_start_reg ? 1'b0 : bright_reg;
        c_mode     = s1_start_reg ? SGR_NORMAL : mode_reg;
        c_prev     = s1_start_reg ? CH_BRACKET : prev_reg;
    end

    // closing of the current parameter
    always_comb
    begin
        f_first    = (c_idx == 3'd0) ? c_accum : c_first;
        f_first_v  = (c_idx == 3'd0) ? c_has : c_first_v;
        f_second   = (c_idx == 3'd1) ? c_accum : c_second;
        f_second_v = (c_idx == 3'd1) ? c_has : c_second_v;
        f_idx      = (c_idx < 3'd7) ? c_idx + 3'd1 : c_idx;
        f_color    = c_color;
        f_color_v  = c_color_v;
        f_bright   = c_bright;
        f_mode     = c_mode;
        unique case (c_mode)
            SGR_NORMAL:
            begin
                if (c_idx == 3'd1 && c_first_v && c_first == 16'd38 && c_has
                    && (c_accum == 16'd2 || c_accum == 16'd5))
                begin
                    f_mode = (c_accum == 16'd2) ? SGR_TRUECOLOR : SGR_WAIT_INDEX;
                end
                else if (c_has)
                begin
                    if (c_accum == 16'd0)
                    begin
                        f_color   = PAL_DEFAULT;
                        f_color_v = 1'b1;
                        f_bright  = 1'b0;
                    end
                    else if (c_accum == 16'd1)
                    begin
                        f_bright = 1'b1;
                    end
                    else if (c_accum >= 16'd30 && c_accum <= 16'd37)
                    begin
                        f_color   = PAL_W'(c_accum - 16'd30);
                        f_color_v = 1'b1;
                    end
                    else if (c_accum >= 16'd40 && c_accum <= 16'd47)
                    begin
                        f_color   = PAL_W'(c_accum - 16'd40);
                        f_color_v = 1'b1;
                    end
                    else if (c_accum >= 16'd90 && c_accum <= 16'd97)
                    begin
                        f_color   = PAL_W'(c_accum - 16'd82);
                        f_color_v = 1'b1;
                    end
                    else if (c_accum >= 16'd100 && c_accum <= 16'd107)
                    begin
                        f_color   = PAL_W'(c_accum - 16'd92);
                        f_color_v = 1'b1;
                    end
                    else if (c_accum == 16'd39 || c_accum == 16'd49)
                    begin
                        f_color   = PAL_DEFAULT;
                        f_color_v = 1'b1;
                    end
                end
            end
            SGR_WAIT_INDEX:
            begin
                if (c_has)
                begin
                    if (c_accum <= 16'd15)
                    begin
                        f_color   = c_accum[PAL_W-1:0];
                        f_color_v = 1'b1;
                    end
                    else
                    begin
                        f_color_v = 1'b0;
                    end
                    f_mode = SGR_INDEX_TAKEN;
                end
                else
                begin
                    f_mode = SGR_NORMAL;
                end
            end
            default:
            begin
                f_mode = c_mode;
            end
        endcase
    end

    // byte decode, result and next parse state
    always_comb
    begin
        is_digit   = s1_byte_reg >= CH_ZERO && s1_byte_reg <= CH_NINE;
        is_final   = s1_byte_reg == CH_SET || s1_byte_reg == CH_RESET
                  || s1_byte_reg == CH_UP || s1_byte_reg == CH_DOWN
                  || s1_byte_reg == CH_RIGHT || s1_byte_reg == CH_LEFT
                  || s1_byte_reg == CH_POS_H || s1_byte_reg == CH_POS_F
                  || s1_byte_reg == CH_CLR_SCR || s1_byte_reg == CH_CLR_LN
                  || s1_byte_reg == CH_SAVE || s1_byte_reg == CH_RESTORE
                  || s1_byte_reg == CH_SGR;
        first_byte = c_count == 8'd0;
        acc_wide   = {1'b0, c_accum, 3'b000} + {3'b000, c_accum, 1'b0}
                   + {16'd0, s1_byte_reg[3:0]};
        amt        = f_first_v ? f_first : 16'd1;
        lim_h      = (height_reg == '0) ? 8'd0
                   : (height_reg > 9'd256) ? 8'd255 : POS_W'(height_reg - 9'd1);
        lim_w      = (width_reg == '0) ? 8'd0
                   : (width_reg > 9'd256) ? 8'd255 : POS_W'(width_reg - 9'd1);
        sum_row    = {9'd0, s1_row_reg} + {1'b0, amt};
        sum_col    = {9'd0, s1_col_reg} + {1'b0, amt};
        sgr_c      = (f_bright && !f_color[PAL_W-1]) ? f_color + 4'd8 : f_color;

        count_next     = (c_count < 8'd255) ? c_count + 8'd1 : c_count;
        accum_next     = c_accum;
        has_next       = c_has;
        first_next     = c_first;
        first_v_next   = c_first_v;
        second_next    = c_second;
        second_v_next  = c_second_v;
        idx_next       = c_idx;
        color_next     = c_color;
        color_v_next   = c_color_v;
        bright_next    = c_bright;
        mode_next      = c_mode;
        prev_next      = s1_byte_reg;
        saved_col_next = saved_col_reg;
        saved_row_next = saved_row_reg;

        r_done = 1'b0;
        r_cnt  = 8'd0;
        r_col  = s1_col_reg;
        r_row  = s1_row_reg;
        r_pal  = s1_pal_reg;
        r_ck   = CLEAR_NONE;
        r_ca   = 8'd0;

        if (is_digit)
        begin
            accum_next = (acc_wide > 20'd65535) ? 16'hFFFF : acc_wide[PARAM_W-1:0];
            has_next   = 1'b1;
        end
        else if (s1_byte_reg == CH_SEMI)
        begin
            first_next    = f_first;
            first_v_next  = f_first_v;
            second_next   = f_second;
            second_v_next = f_second_v;
            idx_next      = f_idx;
            color_next    = f_color;
            color_v_next  = f_color_v;
            bright_next   = f_bright;
            mode_next     = f_mode;
            accum_next    = '0;
            has_next      = 1'b0;
        end
        else if (is_final)
        begin
            r_done = 1'b1;
            r_cnt  = count_next;
            unique case (s1_byte_reg)
                CH_UP:
                begin
                    r_row = ({8'd0, s1_row_reg} < amt) ? 8'd0 : POS_W'({8'd0, s1_row_reg} - amt);
                end
                CH_DOWN:
                begin
                    r_row = (sum_row > {9'd0, lim_h}) ? lim_h : sum_row[POS_W-1:0];
                end
                CH_RIGHT:
                begin
                    r_col = (sum_col > {9'd0, lim_w}) ? lim_w : sum_col[POS_W-1:0];
                end
                CH_LEFT:
                begin
                    r_col = ({8'd0, s1_col_reg} < amt) ? 8'd0 : POS_W'({8'd0, s1_col_reg} - amt);
                end
                CH_POS_H, CH_POS_F:
                begin
                    if (f_first_v)
                    begin
                        r_row = (f_first > 16'd255) ? 8'd255 : f_first[POS_W-1:0];
                        if (f_second_v)
                        begin
                            r_col = (f_second > 16'd255) ? 8'd255 : f_second[POS_W-1:0];
                        end
                    end
                end
                CH_CLR_SCR:
                begin
                    r_ck = CLEAR_SCREEN;
                    r_ca = c_prev;
                end
                CH_CLR_LN:
                begin
                    r_ck = CLEAR_LINE;
                    r_ca = c_prev;
                end
                CH_SAVE:
                begin
                    saved_col_next = s1_col_reg;
                    saved_row_next = s1_row_reg;
                end
                CH_RESTORE:
                begin
                    r_col = saved_col_reg;
                    r_row = saved_row_reg;
                end
                CH_SGR:
                begin
                    priority if (first_byte)
                    begin
                        r_pal = PAL_DEFAULT;
                    end
                    else if (f_mode == SGR_TRUECOLOR)
                    begin
                        r_pal = s1_pal_reg;
                    end
                    else if (f_mode == SGR_INDEX_TAKEN)
                    begin
                        if (f_color_v)
                        begin
                            r_pal = f_color;
                        end
                    end
                    else if (f_color_v)
                    begin
                        r_pal = sgr_c;
                    end
                    else if (f_bright)
                    begin
                        r_pal = s1_pal_reg[PAL_W-1] ? s1_pal_reg : s1_pal_reg + 4'd8;
                    end
                    else
                    begin
                        r_pal = s1_pal_reg;
                    end
                end
                default:
                begin
                    r_ck = CLEAR_NONE;
                end
            endcase
            // sequence ends: back to a clean parse state
            count_next    = 8'd0;
            accum_next    = '0;
            has_next      = 1'b0;
            first_next    = '0;
            first_v_next  = 1'b0;
            second_next   = '0;
            second_v_next = 1'b0;
            idx_next      = 3'd0;
            color_next    = '0;
            color_v_next  = 1'b0;
            bright_next   = 1'b0;
            mode_next     = SGR_NORMAL;
            prev_next     = CH_BRACKET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_WIDTH:  width_reg  <= cfg_data;
                REG_WINDOW_HEIGHT: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            saved_col_reg <= '0;
            saved_row_reg <= '0;
            count_reg     <= '0;
            accum_reg     <= '0;
            has_reg       <= 1'b0;
            first_reg     <= '0;
            first_v_reg   <= 1'b0;
            second_reg    <= '0;
            second_v_reg  <= 1'b0;
            idx_reg       <= '0;
            color_reg     <= '0;
            color_v_reg   <= 1'b0;
            bright_reg    <= 1'b0;
            mode_reg      <= SGR_NORMAL;
            prev_reg      <= CH_BRACKET;
        end
        else
        begin
            if (seq_ch.ready)
            begin
                s1_valid_reg <= seq_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                saved_col_reg <= saved_col_next;
                saved_row_reg <= saved_row_next;
                count_reg     <= count_next;
                accum_reg     <= accum_next;
                has_reg       <= has_next;
                first_reg     <= first_next;
                first_v_reg   <= first_v_next;
                second_reg    <= second_next;
                second_v_reg  <= second_v_next;
                idx_reg       <= idx_next;
                color_reg     <= color_next;
                color_v_reg   <= color_v_next;
                bright_reg    <= bright_next;
                mode_reg      <= mode_next;
                prev_reg      <= prev_next;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_ch.valid && seq_ch.ready)
        begin
            s1_byte_reg  <= seq_ch.seq_byte;
            s1_start_reg <= seq_ch.start_req;
            s1_col_reg   <= seq_ch.cursor_col_in;
            s1_row_reg   <= seq_ch.cursor_row_in;
            s1_pal_reg   <= seq_ch.palette_in;
        end
        if (advance)
        begin
            out_done_reg <= r_done;
            out_cnt_reg  <= r_cnt;
            out_col_reg  <= r_col;
            out_row_reg  <= r_row;
            out_pal_reg  <= r_pal;
            out_ck_reg   <= r_ck;
            out_ca_reg   <= r_ca;
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

import acsp_pkg::*;

localparam int unsigned SGR_RESET          = 0;
localparam int unsigned SGR_BRIGHT         = 1;
localparam int unsigned SGR_EXT_TRUE       = 2;
localparam int unsigned SGR_EXT_INDEX      = 5;
localparam int unsigned SGR_FG_BASE        = 30;
localparam int unsigned SGR_FG_TOP         = 37;
localparam int unsigned SGR_EXTENDED       = 38;
localparam int unsigned SGR_FG_DEFAULT     = 39;
localparam int unsigned SGR_BG_BASE        = 40;
localparam int unsigned SGR_BG_TOP         = 47;
localparam int unsigned SGR_BG_DEFAULT     = 49;
localparam int unsigned SGR_FG_BRIGHT_BASE = 90;
localparam int unsigned SGR_FG_BRIGHT_TOP  = 97;
localparam int unsigned SGR_BG_BRIGHT_BASE = 100;
localparam int unsigned SGR_BG_BRIGHT_TOP  = 107;
localparam int unsigned BRIGHT_SHIFT       = 8;
localparam int unsigned PARAM_MAX          = 65535;
localparam int unsigned COORD_MAX          = 255;
localparam int unsigned COUNT_MAX          = 255;
localparam int unsigned PARAM_SLOT_MAX     = 7;

typedef struct packed {
    logic [7:0] code;
    logic       fresh;
    logic [7:0] col;
    logic [7:0] row;
    logic [3:0] pal;
} csi_byte_t;

typedef struct packed {
    logic        done;
    logic [7:0]  consumed;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [3:0]  pal;
    clear_kind_t kind;
    logic [7:0]  arg;
} csi_outcome_t;

class console_effects;
    csi_outcome_t awaited[$];
    int unsigned  failures;

    int unsigned  width;
    int unsigned  height;
    int unsigned  saved_col;
    int unsigned  saved_row;
    int unsigned  count;
    int unsigned  accum;
    bit           has_digits;
    int unsigned  p0;
    bit           p0_ok;
    int unsigned  p1;
    bit           p1_ok;
    int unsigned  slot;
    int unsigned  color;
    bit           color_ok;
    bit           bright;
    sgr_mode_t    mode;
    logic [7:0]   prev;

    function new();
        failures  = 0;
        width     = WIDTH_RESET;
        height    = HEIGHT_RESET;
        saved_col = 0;
        saved_row = 0;
        restart();
    endfunction

    function void set_window(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        if (idx == REG_WINDOW_WIDTH)
            width = v;
        else
            height = v;
    endfunction

    function int unsigned outstanding();
        return awaited.size();
    endfunction

    function void restart();
        count      = 0;
        accum      = 0;
        has_digits = 0;
        p0         = 0;
        p0_ok      = 0;
        p1         = 0;
        p1_ok      = 0;
        slot       = 0;
        color      = 0;
        color_ok   = 0;
        bright     = 0;
        mode       = SGR_NORMAL;
        prev       = CH_BRACKET;
    endfunction

    function void apply_sgr(int unsigned v);
        if (v == SGR_RESET)
        begin
            color = PAL_DEFAULT; color_ok = 1; bright = 0;
        end
        else if (v == SGR_BRIGHT)
            bright = 1;
        else if (v >= SGR_FG_BASE && v <= SGR_FG_TOP)
        begin
            color = v - SGR_FG_BASE; color_ok = 1;
        end
        else if (v >= SGR_BG_BASE && v <= SGR_BG_TOP)
        begin
            color = v - SGR_BG_BASE; color_ok = 1;
        end
        else if (v >= SGR_FG_BRIGHT_BASE && v <= SGR_FG_BRIGHT_TOP)
        begin
            color = v - SGR_FG_BRIGHT_BASE + BRIGHT_SHIFT; color_ok = 1;
        end
        else if (v >= SGR_BG_BRIGHT_BASE && v <= SGR_BG_BRIGHT_TOP)
        begin
            color = v - SGR_BG_BRIGHT_BASE + BRIGHT_SHIFT; color_ok = 1;
        end
        else if (v == SGR_FG_DEFAULT || v == SGR_BG_DEFAULT)
        begin
            color = PAL_DEFAULT; color_ok = 1;
        end
    endfunction

    function void close_param();
        int unsigned v;
        bit          h;
        v = accum;
        h = has_digits;
        if (slot == 0)
        begin
            p0 = v; p0_ok = h;
        end
        else if (slot == 1)
        begin
            p1 = v; p1_ok = h;
        end
        if (mode == SGR_NORMAL)
        begin
            if (slot == 1 && p0_ok && p0 == SGR_EXTENDED && h
                && (v == SGR_EXT_TRUE || v == SGR_EXT_INDEX))
                mode = (v == SGR_EXT_TRUE) ? SGR_TRUECOLOR : SGR_WAIT_INDEX;
            else if (h)
                apply_sgr(v);
        end
        else if (mode == SGR_WAIT_INDEX)
        begin
            if (h)
            begin
                if (v <= PAL_DEFAULT)
                begin
                    color = v; color_ok = 1;
                end
                else
                    color_ok = 0;
                mode = SGR_INDEX_TAKEN;
            end
            else
                mode = SGR_NORMAL;
        end
        if (slot < PARAM_SLOT_MAX)
            slot++;
        accum      = 0;
        has_digits = 0;
    endfunction

    function int unsigned span_max(int unsigned size);
        if (size == 0)
            return 0;
        return (size - 1 > COORD_MAX) ? COORD_MAX : size - 1;
    endfunction

    function bit ends_sequence(logic [7:0] b);
        case (b)
            CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_POS_H, CH_POS_F, CH_CLR_SCR,
            CH_CLR_LN, CH_SAVE, CH_RESTORE, CH_SET, CH_RESET, CH_SGR: return 1;
            default: return 0;
        endcase
    endfunction

    function void note_byte(csi_byte_t it);
        csi_outcome_t r;
        bit           lead;
        bit           fin;
        int unsigned  amt;
        int unsigned  lim;
        int unsigned  sum;
        int unsigned  acc;
        int unsigned  c;
        r.done     = 0;
        r.consumed = 0;
        r.col      = it.col;
        r.row      = it.row;
        r.pal      = it.pal;
        r.kind     = CLEAR_NONE;
        r.arg      = 0;
        if (it.fresh)
            restart();
        lead = (count == 0);
        if (count < COUNT_MAX)
            count++;
        fin = ends_sequence(it.code);
        if (it.code >= CH_ZERO && it.code <= CH_NINE)
        begin
            acc        = accum * 10 + (it.code - CH_ZERO);
            accum      = (acc > PARAM_MAX) ? PARAM_MAX : acc;
            has_digits = 1;
        end
        else if (it.code == CH_SEMI)
            close_param();
        else if (fin)
        begin
            close_param();
            amt        = p0_ok ? p0 : 1;
            r.done     = 1;
            r.consumed = 8'(count);
            case (it.code)
                CH_UP:    r.row = 8'((it.row < amt) ? 0 : it.row - amt);
                CH_DOWN:
                begin
                    lim   = span_max(height);
                    sum   = it.row + amt;
                    r.row = 8'((sum > lim) ? lim : sum);
                end
                CH_RIGHT:
                begin
                    lim   = span_max(width);
                    sum   = it.col + amt;
                    r.col = 8'((sum > lim) ? lim : sum);
                end
                CH_LEFT:  r.col = 8'((it.col < amt) ? 0 : it.col - amt);
                CH_POS_H, CH_POS_F:
                begin
                    if (p0_ok)
                    begin
                        r.row = 8'((p0 > COORD_MAX) ? COORD_MAX : p0);
                        if (p1_ok)
                            r.col = 8'((p1 > COORD_MAX) ? COORD_MAX : p1);
                    end
                end
                CH_CLR_SCR:
                begin
                    r.kind = CLEAR_SCREEN; r.arg = prev;
                end
                CH_CLR_LN:
                begin
                    r.kind = CLEAR_LINE; r.arg = prev;
                end
                CH_SAVE:
                begin
                    saved_col = it.col; saved_row = it.row;
                end
                CH_RESTORE:
                begin
                    r.col = 8'(saved_col); r.row = 8'(saved_row);
                end
                CH_SGR:
                begin
                    if (lead)
                        r.pal = PAL_DEFAULT;
                    else if (mode == SGR_TRUECOLOR)
                        r.pal = it.pal;
                    else if (mode == SGR_INDEX_TAKEN)
                    begin
                        if (color_ok)
                            r.pal = color[3:0];
                    end
                    else if (color_ok)
                    begin
                        c = color & PAL_DEFAULT;
                        if (bright && c < BRIGHT_SHIFT)
                            c += BRIGHT_SHIFT;
                        r.pal = 4'(c);
                    end
                    else if (bright)
                        r.pal = 4'((it.pal < BRIGHT_SHIFT) ? it.pal + BRIGHT_SHIFT : it.pal);
                end
                default: ;
            endcase
            restart();
        end
        if (!fin)
            prev = it.code;
        awaited.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] seen);
        if (seen !== want)
        begin
            failures++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
        end
    endfunction

    function void check_effect(csi_outcome_t got);
        csi_outcome_t want;
        if (awaited.size() == 0)
        begin
            failures++;
            $display("%0t: unexpected result, expected nothing, got %h", $time, got);
            return;
        end
        want = awaited.pop_front();
        compare("done_res", want.done, got.done);
        compare("consumed", want.consumed, got.consumed);
        compare("cursor_col", want.col, got.col);
        compare("cursor_row", want.row, got.row);
        compare("palette", want.pal, got.pal);
        compare("clear_kind", want.kind, got.kind);
        compare("clear_arg", want.arg, got.arg);
    endfunction
endclass

module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned IDLE_PCT    = 22;
    localparam int unsigned ITEM_GOAL   = 1150;
    localparam int unsigned PHASES      = 6;
    localparam logic [7:0]  FILLER_LO   = 8'h20;
    localparam logic [7:0]  FILLER_HI   = 8'h2F;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIN_W-1:0] cfg_data;

    acsp_seq_if seq_ch ();
    acsp_res_if res_ch ();

    console_effects book;
    bit             calm;
    bit             lead_pending;
    int unsigned    sent;
    int unsigned    cycles;
    int unsigned    args[$];
    bit             given[$];

    ansi_csi_sequence_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seq_ch    (seq_ch),
        .res_ch    (res_ch)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        res_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        csi_outcome_t got;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.done     = res_ch.done_res;
            got.consumed = res_ch.consumed;
            got.col      = res_ch.cursor_col;
            got.row      = res_ch.cursor_row;
            got.pal      = res_ch.palette;
            got.kind     = clear_kind_t'(res_ch.clear_kind);
            got.arg      = res_ch.clear_arg;
            book.check_effect(got);
        end
    end

    task automatic push_item(input csi_byte_t it);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            seq_ch.valid <= 0;
            @(negedge clk);
        end
        seq_ch.valid         <= 1;
        seq_ch.seq_byte      <= it.code;
        seq_ch.start_req     <= it.fresh;
        seq_ch.cursor_col_in <= it.col;
        seq_ch.cursor_row_in <= it.row;
        seq_ch.palette_in    <= it.pal;
        forever
        begin
            @(posedge clk);
            if (seq_ch.ready === 1'b1)
                break;
        end
        book.note_byte(it);
        sent++;
        @(negedge clk);
    endtask

    task automatic send(input logic [7:0] code);
        csi_byte_t it;
        it.code      = code;
        it.fresh     = lead_pending;
        it.col       = 8'($urandom_range(255));
        it.row       = 8'($urandom_range(255));
        it.pal       = 4'($urandom_range(15));
        lead_pending = 0;
        push_item(it);
    endtask

    task automatic open_seq();
        lead_pending = 1;
    endtask

    task automatic send_number(input int unsigned v);
        string digits;
        digits = $sformatf("%0d", v);
        for (int k = 0; k < digits.len(); k++)
            send(digits[k]);
    endtask

    task automatic hold_until_drained();
        seq_ch.valid <= 0;
        @(negedge clk);
        while (book.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= WIN_W'(v);
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
        book.set_window(idx, v);
    endtask

    task automatic push_arg(input bit has, input int unsigned v);
        given.push_back(has);
        args.push_back(v);
    endtask

    task automatic emit_args();
        for (int k = 0; k < args.size(); k++)
        begin
            if (given[k])
                send_number(args[k]);
            if (k < args.size() - 1)
                send(CH_SEMI);
        end
    endtask

    function automatic int unsigned pick_sgr();
        case ($urandom_range(7))
            0: return SGR_RESET;
            1: return SGR_BRIGHT;
            2: return SGR_FG_BASE + $urandom_range(7);
            3: return SGR_BG_BASE + $urandom_range(7);
            4: return SGR_FG_BRIGHT_BASE + $urandom_range(7);
            5: return SGR_BG_BRIGHT_BASE + $urandom_range(7);
            6: return $urandom_range(1) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
            default: return $urandom_range(120);
        endcase
    endfunction

    function automatic int unsigned pick_plain();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 5)
            return $urandom_range(9);
        if (r < 8)
            return $urandom_range(300);
        if (r == 8)
            return $urandom_range(99999, 60000);
        return 0;
    endfunction

    function automatic logic [7:0] pick_final();
        case ($urandom_range(12))
            0:  return CH_UP;
            1:  return CH_DOWN;
            2:  return CH_RIGHT;
            3:  return CH_LEFT;
            4:  return CH_POS_H;
            5:  return CH_POS_F;
            6:  return CH_CLR_SCR;
            7:  return CH_CLR_LN;
            8:  return CH_SAVE;
            9:  return CH_RESTORE;
            10: return CH_SET;
            11: return CH_RESET;
            default: return CH_SGR;
        endcase
    endfunction

    task automatic sgr_args();
        repeat ($urandom_range(1) ? 0 : $urandom_range(2))
            push_arg($urandom_range(5) != 0, pick_sgr());
        if ($urandom_range(2) == 0)
        begin
            push_arg(1, SGR_EXTENDED);
            if ($urandom_range(1))
            begin
                push_arg(1, SGR_EXT_INDEX);
                push_arg($urandom_range(7) != 0, $urandom_range(20));
            end
            else
            begin
                push_arg(1, SGR_EXT_TRUE);
                repeat (3)
                    push_arg(1, $urandom_range(255));
            end
        end
        repeat ($urandom_range(3))
            push_arg($urandom_range(5) != 0, pick_sgr());
    endtask

    task automatic plain_args();
        repeat ($urandom_range(2))
            push_arg($urandom_range(4) != 0, pick_plain());
    endtask

    task automatic random_sequence();
        int unsigned pick;
        logic [7:0]  fin;
        args.delete();
        given.delete();
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            fin = pick_final();
            if (fin == CH_SGR)
                sgr_args();
            else
                plain_args();
            open_seq();
            emit_args();
            if ($urandom_range(19) == 0)
                send(8'($urandom_range(FILLER_HI, FILLER_LO)));
            send(fin);
        end
        else if (pick < 85)
        begin
            // abandoned sequence, the next start drops it
            plain_args();
            open_seq();
            emit_args();
        end
        else
        begin
            repeat ($urandom_range(6, 1))
            begin
                lead_pending = ($urandom_range(1) != 0);
                send(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_directed();
        open_seq(); send(CH_ZERO); send(CH_UP);
        open_seq(); send(CH_DOWN);
        open_seq(); send_number(99999); send(CH_RIGHT);
        open_seq(); send(CH_LEFT);
        open_seq(); send_number(300); send(CH_SEMI); send_number(7); send(CH_POS_H);
        open_seq(); send(CH_POS_F);
        open_seq(); send(CH_SAVE);
        open_seq(); send(CH_RESTORE);
        open_seq(); send(CH_SET);
        open_seq(); send(CH_RESET);
        open_seq(); send(CH_CLR_SCR);
        open_seq(); send_number(2); send(CH_CLR_LN);
        open_seq(); send(CH_SGR);
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned goal;
        book                 = new();
        calm                 = 0;
        lead_pending         = 0;
        sent                 = 0;
        cycles               = 0;
        rst_n                = 0;
        cfg_we               = 0;
        cfg_index            = REG_WINDOW_WIDTH;
        cfg_data             = 0;
        seq_ch.valid         = 0;
        seq_ch.seq_byte      = 0;
        seq_ch.start_req     = 0;
        seq_ch.cursor_col_in = 0;
        seq_ch.cursor_row_in = 0;
        seq_ch.palette_in    = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        run_directed();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin w = 1;   h = 1;   end
                1: begin w = 256; h = 256; end
                2: begin w = 1;   h = 256; end
                3: begin w = 256; h = 1;   end
                4: begin w = 80;  h = 25;  end
                default:
                begin
                    w = $urandom_range(256, 1);
                    h = $urandom_range(256, 1);
                end
            endcase
            hold_until_drained();
            repeat (3) @(negedge clk);
            write_window(REG_WINDOW_WIDTH, w);
            write_window(REG_WINDOW_HEIGHT, h);
            calm = (ph == 2);
            if (ph == 1)
            begin
                // count and parameter both saturate
                open_seq();
                repeat (260) send(CH_NINE);
                send(CH_RIGHT);
            end
            goal = ITEM_GOAL * (ph + 1) / PHASES;
            while (sent < goal)
                random_sequence();
        end
        calm = 0;

        hold_until_drained();
        repeat (10) @(negedge clk);
        if (book.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
